/* sv/binary_to_eight_bcd_digits_macros.svh */
// Assertion macros shared by the binary to BCD checker.
`ifndef BINARY_TO_EIGHT_BCD_DIGITS_MACROS_SVH
`define BINARY_TO_EIGHT_BCD_DIGITS_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define B2BCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define B2BCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/b2bcd_pkg.sv */
// Types and constants for the binary to eight BCD digit converter.
package b2bcd_pkg;

    localparam int unsigned IN_W     = 32;
    localparam int unsigned DIGITS   = 8;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    // 99999999 needs 27 bits, so the saturated value is shifted 27 times
    localparam int unsigned SRC_W    = 27;
    localparam int unsigned CNT_W    = 5;
    localparam logic [IN_W-1:0] BCD_LIMIT = 32'd99999999;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_core_ctrl;

    typedef struct packed {
        logic last;
    } t_core_stat;

    // add 3 to every nibble of 5 or more before the shift
    function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic [3:0]       nib;
        res = bcd;
        for (int k = 0; k < DIGITS; k++) begin
            nib = bcd[4*k +: 4];
            if (nib >= 4'd5) begin
                res[4*k +: 4] = nib + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

/* sv/b2bcd_core.sv */
// Iterative shift-and-add-3 engine: one binary bit per step.
module b2bcd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  b2bcd_pkg::t_core_ctrl          i_ctrl,
    input  logic [b2bcd_pkg::IN_W-1:0]     i_value,
    output b2bcd_pkg::t_core_stat          o_stat,
    output logic [b2bcd_pkg::BCD_W-1:0]    o_bcd
);
    import b2bcd_pkg::*;

    logic [SRC_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [BCD_W-1:0] adj;
    logic [IN_W-1:0]  sat;

    assign sat = (i_value > BCD_LIMIT) ? BCD_LIMIT : i_value;
    assign adj = dabble_adjust(r_bcd);

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            n_bin = sat[SRC_W-1:0];
            n_bcd = '0;
            n_cnt = CNT_W'(SRC_W);
        end else if (i_ctrl.step) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[SRC_W-1]};
            n_bin = {r_bin[SRC_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_stat.last = (r_cnt == CNT_W'(1));
    assign o_bcd       = r_bcd;

endmodule

/* sv/binary_to_eight_bcd_digits.sv */
// Binary to eight BCD digit converter, top level with stream handshakes.
//
// Takes one 32-bit unsigned value per input beat and returns its eight
// decimal digits in one output beat. Values above 99999999 saturate, so all
// digits read 9. The conversion is shift-and-add-3 done one bit per cycle in
// a single shared engine (b2bcd_core): the saturated value is 27 bits wide,
// so the value is loaded at its accepting edge, then shifted 27 times, and
// the result then moves to the output register once that has room. The
// next input beat can be taken in the cycle after that transfer.
// The engine holds one item at a time: o_s_axis_tready is low from the
// accepting edge until the result moves to the output register. The output
// register is separate from the engine, so a new input beat is taken while
// an earlier result still waits for i_m_axis_tready; if the next result is
// done first, the engine holds it until the output register frees up.
// Output tdata packs the digits four bits each, ten-millions digit in the
// lowest nibble and units digit in the highest.
module binary_to_eight_bcd_digits (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [b2bcd_pkg::IN_W-1:0]     i_s_axis_tdata,  // [31:0] binary_value
    // master side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [3:0] digit_ten_millions, [7:4] digit_millions,
    // [11:8] digit_hundred_thousands, [15:12] digit_ten_thousands,
    // [19:16] digit_thousands, [23:20] digit_hundreds,
    // [27:24] digit_tens, [31:28] digit_units
    output logic [b2bcd_pkg::BCD_W-1:0]    o_m_axis_tdata
);
    import b2bcd_pkg::*;

    t_state           r_state, n_state;
    t_core_ctrl       ctrl;
    t_core_stat       stat;
    logic [BCD_W-1:0] core_bcd;
    logic [BCD_W-1:0] beat_data;
    logic             r_out_valid, n_out_valid;
    logic [BCD_W-1:0] r_out_data;
    logic             out_load;

    b2bcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_value (i_s_axis_tdata),
        .o_stat  (stat),
        .o_bcd   (core_bcd)
    );

    // engine keeps units in the low nibble; the beat wants ten-millions there
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            beat_data[4*k +: 4] = core_bcd[4*(DIGITS-1-k) +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        ctrl            = '0;
        out_load        = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    ctrl.load = 1'b1;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                ctrl.step = 1'b1;
                if (stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for room in the output register
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (out_load) begin
            r_out_data <= beat_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* sv/b2bcd_checker.sv */
// Port-level checks for the binary to BCD converter, bound to the top level.
`include "binary_to_eight_bcd_digits_macros.svh"

module b2bcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    logic in_beat;
    logic out_stall;
    logic digits_ok;

    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    always_comb begin
        digits_ok = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (o_m_axis_tdata[4*k +: 4] > 4'd9) begin
                digits_ok = 1'b0;
            end
        end
    end

    // stalled result holds
    `B2BCD_ASSERT(a_out_hold, out_stall |=> o_m_axis_tvalid, "stalled output beat dropped")
    `B2BCD_ASSERT(a_out_stable, out_stall |=> $stable(o_m_axis_tdata), "stalled beat changed")

    // every digit of a shown result is decimal
    `B2BCD_ASSERT(a_digits_dec, o_m_axis_tvalid |-> digits_ok, "digit above nine")

    // one item at a time: busy after an input beat
    `B2BCD_ASSERT(a_busy_after_in, in_beat |=> !o_s_axis_tready, "input taken while converting")

    // reset empties the output register
    `B2BCD_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind binary_to_eight_bcd_digits b2bcd_checker u_b2bcd_checker (.*);
